FILE: rtl/core/tlfq_pkg.sv
package tlfq_pkg;

  localparam int DEF_NUM_SLOTS = 64;
  localparam int LEVELS = 3;
  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  localparam logic [15:0] RST_Q0 = 16'd1;
  localparam logic [15:0] RST_Q1 = 16'd2;
  localparam logic [15:0] RST_Q2 = 16'd8;
  localparam logic [15:0] RST_BOOST = 16'd50;

  typedef enum logic [1:0] {
    FN_ADMIT = 2'd0,
    FN_SETRUN = 2'd1,
    FN_PICK = 2'd2,
    FN_REPORT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_Q0 = 2'd0,
    REG_Q1 = 2'd1,
    REG_Q2 = 2'd2,
    REG_BOOST = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] q0;
    logic [15:0] q1;
    logic [15:0] q2;
    logic [15:0] boost;
  } cfg_regs_t;

endpackage

FILE: rtl/core/tlfq_if.sv
interface tlfq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [5:0] slot;
  logic [5:0] position;
  logic       runnable;
  logic [15:0] duration;
  modport source (output valid, func, slot, position, runnable, duration, input ready);
  modport sink (input valid, func, slot, position, runnable, duration, output ready);
endinterface

interface tlfq_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] chosen_slot;
  logic [1:0] chosen_level;
  logic [5:0] chosen_position;
  logic       found;
  logic       demoted;
  logic [6:0] boosted_count;
  modport source (output valid, chosen_slot, chosen_level, chosen_position, found, demoted,
                  boosted_count, input ready);
  modport sink (input valid, chosen_slot, chosen_level, chosen_position, found, demoted,
                boosted_count, output ready);
endinterface

interface tlfq_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tlfq_cfg.sv
module tlfq_cfg
  import tlfq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tlfq_cfg_if.sink   cfg,
  output cfg_regs_t  regs
);

  cfg_regs_t regs_r;

  assign cfg.ready = 1'b1;
  assign regs = regs_r;

  // Register file written one beat at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{q0: RST_Q0, q1: RST_Q1, q2: RST_Q2, boost: RST_BOOST};
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_Q0: regs_r.q0 <= cfg.data;
        REG_Q1: regs_r.q1 <= cfg.data;
        REG_Q2: regs_r.q2 <= cfg.data;
        REG_BOOST: regs_r.boost <= cfg.data;
        default: regs_r <= regs_r;
      endcase
    end
  end

endmodule

FILE: rtl/core/tlfq_engine.sv
module tlfq_engine
  import tlfq_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  regs,
  tlfq_in_if.sink    in_ch,
  tlfq_out_if.source out_ch
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam int AW = $clog2(LEVELS * NUM_SLOTS);
  localparam logic [LW-1:0] NFULL = LW'(NUM_SLOTS);
  localparam int CW = $clog2(3 * NUM_SLOTS + 9);
  localparam logic [CW-1:0] PICK_STEPS = CW'(3 * NUM_SLOTS + 8);

  typedef enum logic [3:0] {
    S_IDLE, S_PURGE, S_SHIFT, S_APPEND, S_PICK, S_RLOOK, S_RDEC,
    S_AGE, S_AGEW, S_OUT
  } state_t;

  // Queue memory (levels stacked) and per-slot wait-time memory.
  logic [5:0]  qmem [LEVELS*NUM_SLOTS];
  logic [15:0] wmem [NUM_SLOTS];
  logic [AW-1:0] q_raddr, q_waddr;
  logic          q_we;
  logic [5:0]    q_wdata, q_rdata_r;
  logic [SW-1:0] w_raddr, w_waddr;
  logic          w_we;
  logic [15:0]   w_wdata, w_rdata_r;

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    q_rdata_r <= qmem[q_raddr];
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rdata_r <= wmem[w_raddr];
  end

  function automatic logic [AW-1:0] qa(input logic [1:0] l, input logic [LW-1:0] p);
    qa = AW'(l) * AW'(NUM_SLOTS) + AW'(p);
  endfunction

  state_t state_r;
  logic [LW-1:0] len_r [LEVELS];
  logic [NUM_SLOTS-1:0] run_r;
  logic [1:0] cl_r;
  logic [LW-1:0] cp_r;
  // Item registers.
  logic [5:0] slot_r, pos_r;
  logic [15:0] dur_r;
  // Walk registers.
  logic [1:0] lvl_r;
  logic [LW-1:0] p_r;
  logic [CW-1:0] cnt_r;
  logic pend_r;
  // Shift / append control.
  logic [1:0] sh_l_r;
  logic [LW-1:0] sh_j_r;
  logic [1:0] ap_l_r;
  logic [5:0] ap_s_r;
  logic ap_en_r;
  state_t ret_r;
  logic [1:0] rpt_l_r;
  logic [1:0] age_st_r;
  // Result.
  logic [5:0] r_slot_r, r_pos_r;
  logic [1:0] r_lvl_r;
  logic r_found_r, r_dem_r;
  logic [6:0] r_boost_r;
  logic [5:0] age_s_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.chosen_slot = r_slot_r;
  assign out_ch.chosen_level = r_lvl_r;
  assign out_ch.chosen_position = r_pos_r;
  assign out_ch.found = r_found_r;
  assign out_ch.demoted = r_dem_r;
  assign out_ch.boosted_count = r_boost_r;

  logic slot_ok;
  assign slot_ok = (32'(in_ch.slot) < NUM_SLOTS);
  logic run_s;
  assign run_s = (32'(q_rdata_r) < NUM_SLOTS) && run_r[SW'(q_rdata_r)];
  logic [16:0] wsum;
  assign wsum = {1'b0, w_rdata_r} + {1'b0, dur_r};
  logic [15:0] wsat;
  assign wsat = wsum[16] ? WAIT_MAX : wsum[15:0];
  logic [15:0] qsel;
  assign qsel = (rpt_l_r == 2'd0) ? regs.q0 : (rpt_l_r == 2'd1) ? regs.q1 : regs.q2;

  // Memory addressing follows the current state.
  always_comb begin
    q_raddr = qa(lvl_r, p_r);
    q_we = 1'b0;
    q_waddr = qa(ap_l_r, len_r[ap_l_r]);
    q_wdata = ap_s_r;
    w_raddr = SW'(q_rdata_r);
    w_we = 1'b0;
    w_waddr = SW'(age_s_r);
    w_wdata = '0;
    case (state_r)
      S_SHIFT: begin
        // The read address runs two entries ahead of the write address while a copy is in flight.
        q_raddr = qa(sh_l_r, pend_r ? sh_j_r + LW'(2) : sh_j_r + LW'(1));
        q_waddr = qa(sh_l_r, sh_j_r);
        q_wdata = q_rdata_r;
        q_we = pend_r;
      end
      S_APPEND: q_we = ap_en_r && (len_r[ap_l_r] < NFULL);
      S_RLOOK: q_raddr = qa(lvl_r, LW'(pos_r));
      S_IDLE: begin
        w_waddr = SW'(in_ch.slot);
        w_we = in_ch.valid && slot_ok && (func_t'(in_ch.func) == FN_ADMIT);
      end
      S_AGEW: begin
        w_we = 1'b1;
        w_wdata = (wsat > regs.boost && len_r[0] < NFULL) ? 16'd0 : wsat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < LEVELS; i++) len_r[i] <= '0;
      run_r <= '0;
      cl_r <= '0;
      cp_r <= '0;
      pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          slot_r <= in_ch.slot;
          pos_r <= in_ch.position;
          dur_r <= in_ch.duration;
          r_slot_r <= in_ch.slot;
          r_lvl_r <= '0; r_pos_r <= '0; r_found_r <= 1'b0;
          r_dem_r <= 1'b0; r_boost_r <= '0;
          pend_r <= 1'b0;
          lvl_r <= '0; p_r <= '0; cnt_r <= '0;
          if (func_t'(in_ch.func) == FN_PICK) begin
            r_slot_r <= '0;
            lvl_r <= (cl_r > 2'd2) ? 2'd0 : cl_r;
            p_r <= (cl_r > 2'd2) ? '0 : cp_r;
            state_r <= S_PICK;
          end else if (!slot_ok) begin
            state_r <= S_OUT;
          end else if (func_t'(in_ch.func) == FN_SETRUN) begin
            run_r[SW'(in_ch.slot)] <= in_ch.runnable;
            state_r <= S_OUT;
          end else if (func_t'(in_ch.func) == FN_ADMIT) begin
            run_r[SW'(in_ch.slot)] <= 1'b0;
            state_r <= S_PURGE;
          end else begin
            state_r <= S_RLOOK;
          end
        end
        // Search each level for the slot; pend_r marks a read in flight.
        S_PURGE: begin
          if (!pend_r) begin
            if (p_r < len_r[lvl_r]) pend_r <= 1'b1;
            else if (lvl_r == 2'd2) begin
              ap_l_r <= 2'd0; ap_s_r <= slot_r; ap_en_r <= 1'b1;
              r_pos_r <= (len_r[0] < NFULL) ? 6'(len_r[0]) : 6'd0;
              ret_r <= S_OUT;
              state_r <= S_APPEND;
            end else begin
              lvl_r <= lvl_r + 2'd1; p_r <= '0;
            end
          end else begin
            pend_r <= 1'b0;
            if (q_rdata_r == slot_r) begin
              sh_l_r <= lvl_r; sh_j_r <= p_r; ret_r <= S_PURGE;
              lvl_r <= lvl_r + 2'd1; p_r <= '0;
              if (lvl_r == 2'd2) begin
                lvl_r <= 2'd2; p_r <= len_r[2];
              end
              state_r <= S_SHIFT;
            end else p_r <= p_r + LW'(1);
          end
        end
        // Close the gap at sh_j_r by copying each later entry down.
        S_SHIFT: begin
          if (pend_r) sh_j_r <= sh_j_r + LW'(1);
          if ((pend_r ? sh_j_r + LW'(2) : sh_j_r + LW'(1)) < len_r[sh_l_r]) begin
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            len_r[sh_l_r] <= len_r[sh_l_r] - LW'(1);
            state_r <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (ap_en_r && len_r[ap_l_r] < NFULL) len_r[ap_l_r] <= len_r[ap_l_r] + LW'(1);
          ap_en_r <= 1'b0;
          state_r <= ret_r;
          if (ret_r == S_AGE) pend_r <= 1'b0;
        end
        // Cursor walk: request one entry, then test the slot that it returns.
        S_PICK: begin
          if (cnt_r == PICK_STEPS) state_r <= S_OUT;
          else if (!pend_r) begin
            if (p_r < len_r[lvl_r]) pend_r <= 1'b1;
            else begin
              lvl_r <= (lvl_r == 2'd2) ? 2'd0 : lvl_r + 2'd1;
              p_r <= '0;
              cnt_r <= cnt_r + CW'(1);
            end
          end else begin
            pend_r <= 1'b0;
            cnt_r <= cnt_r + CW'(1);
            if (run_s) begin
              r_slot_r <= q_rdata_r; r_lvl_r <= lvl_r; r_pos_r <= 6'(p_r);
              r_found_r <= 1'b1;
              cl_r <= lvl_r; cp_r <= p_r + LW'(1);
              state_r <= S_OUT;
            end else p_r <= p_r + LW'(1);
          end
        end
        // Find the first level whose entry at the position is the slot.
        S_RLOOK: begin
          if (!pend_r) begin
            p_r <= LW'(pos_r);
            if (32'(pos_r) < 32'(len_r[lvl_r])) pend_r <= 1'b1;
            else if (lvl_r == 2'd2) state_r <= S_OUT;
            else lvl_r <= lvl_r + 2'd1;
          end else begin
            pend_r <= 1'b0;
            if (q_rdata_r == slot_r) begin
              rpt_l_r <= lvl_r; r_lvl_r <= lvl_r; r_pos_r <= pos_r;
              state_r <= S_RDEC;
            end else if (lvl_r == 2'd2) state_r <= S_OUT;
            else lvl_r <= lvl_r + 2'd1;
          end
        end
        S_RDEC: begin
          lvl_r <= 2'd2;
          p_r <= (rpt_l_r == 2'd2) ? LW'(pos_r) : '0;
          ret_r <= S_AGE;
          ap_en_r <= 1'b0;
          state_r <= S_AGE;
          if (dur_r >= qsel &&
              (rpt_l_r == 2'd2 || len_r[rpt_l_r + 2'd1] < NFULL)) begin
            r_dem_r <= 1'b1;
            sh_l_r <= rpt_l_r; sh_j_r <= LW'(pos_r);
            ap_l_r <= (rpt_l_r == 2'd2) ? 2'd2 : rpt_l_r + 2'd1;
            ap_s_r <= slot_r; ap_en_r <= 1'b1;
            state_r <= S_SHIFT;
          end
        end
        // Aging: read entry, then its wait time, then update.
        S_AGE: begin
          if (!pend_r) begin
            if (p_r < len_r[2]) pend_r <= 1'b1;
            else state_r <= S_OUT;
            age_st_r <= 2'd0;
          end else if (age_st_r == 2'd0) begin
            age_s_r <= q_rdata_r;
            if (run_s) age_st_r <= 2'd1;
            else begin
              pend_r <= 1'b0; p_r <= p_r + LW'(1);
            end
          end else begin
            state_r <= S_AGEW;
          end
        end
        S_AGEW: begin
          pend_r <= 1'b0;
          age_st_r <= 2'd0;
          if (wsat > regs.boost && len_r[0] < NFULL) begin
            r_boost_r <= r_boost_r + 7'd1;
            sh_l_r <= 2'd2; sh_j_r <= p_r;
            ap_l_r <= 2'd0; ap_s_r <= age_s_r; ap_en_r <= 1'b1;
            ret_r <= S_AGE;
            state_r <= S_SHIFT;
          end else begin
            p_r <= p_r + LW'(1);
            state_r <= S_AGE;
          end
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/three_level_feedback_queue_scheduler_core.sv
// Three-level feedback queue scheduler over task slots.
// Channels: in (func, slot, position, runnable, duration), out (one result
// beat per input beat) and cfg (register index and 16-bit write data).
// The block handles one item at a time: in_ready is high only when idle, and
// the result waits in the output register until out_ready takes the beat.
// The work depends on the event: set runnable goes straight to the output;
// admit scans all three queues (a read, then a compare, per entry) plus the
// shift that closes the gap; pick walks the cursor, one entry read at a time,
// at most 3*NUM_SLOTS+8 steps; a run report adds the shift, the append and an
// aging scan of level 2. All of it is set by the single read port of the
// queue memory and its registered read data.
// Reset (rst_n low, synchronous) empties the queues, clears runnable flags,
// the cursor and loads the default quanta and boost limit. Wait times are
// cleared on admit, which precedes any use of a slot's wait time. A stalled
// receiver holds the block in its output state.
module three_level_feedback_queue_scheduler_core
  import tlfq_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input logic        clk,
  input logic        rst_n,
  tlfq_in_if.sink    in_ch,
  tlfq_out_if.source out_ch,
  tlfq_cfg_if.sink   cfg_ch
);

  cfg_regs_t regs;

  tlfq_cfg u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg_ch), .regs(regs));

  tlfq_engine #(.NUM_SLOTS(NUM_SLOTS)) u_engine (
    .clk(clk), .rst_n(rst_n), .regs(regs), .in_ch(in_ch), .out_ch(out_ch)
  );

endmodule

FILE: tb/three_level_feedback_queue_scheduler_core_tb.sv
`timescale 1ns / 100ps

module three_level_feedback_queue_scheduler_core_tb;
  import tlfq_pkg::*;

  localparam int SLOTS = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    func_t       func;
    logic [5:0]  slot;
    logic [5:0]  position;
    logic        runnable;
    logic [15:0] duration;
  } sched_event_t;

  typedef struct packed {
    logic [5:0] chosen_slot;
    logic [1:0] chosen_level;
    logic [5:0] chosen_position;
    logic       found;
    logic       demoted;
    logic [6:0] boosted_count;
  } sched_result_t;

  // Mirror of the scheduler state, with the queue of results still owed.
  class sched_scoreboard;
    logic [5:0]    queue_slot[3][SLOTS];
    int            queue_len[3];
    bit            is_runnable[SLOTS];
    logic [15:0]   wait_ticks[SLOTS];
    int            cur_level;
    int            cur_pos;
    logic [15:0]   quantum[3];
    logic [15:0]   boost_limit;
    sched_result_t owed[$];
    int            errors;

    function new();
      for (int l = 0; l < 3; l++) queue_len[l] = 0;
      for (int s = 0; s < SLOTS; s++) begin
        is_runnable[s] = 0;
        wait_ticks[s] = '0;
      end
      cur_level = 0;
      cur_pos = 0;
      quantum[0] = RST_Q0;
      quantum[1] = RST_Q1;
      quantum[2] = RST_Q2;
      boost_limit = RST_BOOST;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] value);
      case (idx)
        REG_Q0: quantum[0] = value;
        REG_Q1: quantum[1] = value;
        REG_Q2: quantum[2] = value;
        REG_BOOST: boost_limit = value;
        default: ;
      endcase
    endfunction

    function void drop_entry(int lvl, int pos);
      if (pos >= queue_len[lvl]) return;
      for (int j = pos; j + 1 < queue_len[lvl]; j++) queue_slot[lvl][j] = queue_slot[lvl][j + 1];
      queue_len[lvl]--;
    endfunction

    function bit push_tail(int lvl, logic [5:0] s);
      if (queue_len[lvl] >= SLOTS) return 0;
      queue_slot[lvl][queue_len[lvl]] = s;
      queue_len[lvl]++;
      return 1;
    endfunction

    // Age runnable level 2 entries from first onward and lift the starved ones.
    function int age_and_boost(int first, logic [15:0] dur);
      int i;
      int lifted;
      int sum;
      logic [5:0] s;
      i = first;
      lifted = 0;
      while (i < queue_len[2]) begin
        s = queue_slot[2][i];
        if (is_runnable[s]) begin
          sum = int'(wait_ticks[s]) + int'(dur);
          if (sum > 65535) sum = 65535;
          wait_ticks[s] = sum[15:0];
          if (sum > int'(boost_limit) && queue_len[0] < SLOTS) begin
            wait_ticks[s] = '0;
            drop_entry(2, i);
            void'(push_tail(0, s));
            lifted++;
            continue;
          end
        end
        i++;
      end
      return lifted;
    endfunction

    // Work out the result an accepted event must produce.
    function void note_request(sched_event_t ev);
      sched_result_t r;
      int lvl;
      int p;
      int tgt;
      r = '0;
      r.chosen_slot = ev.slot;
      case (ev.func)
        FN_PICK: begin
          r.chosen_slot = '0;
          lvl = cur_level;
          p = cur_pos;
          if (lvl >= 3) begin
            lvl = 0;
            p = 0;
          end
          for (int step = 0; step < 3 * SLOTS + 8; step++) begin
            if (p < queue_len[lvl]) begin
              if (is_runnable[queue_slot[lvl][p]]) begin
                r.chosen_slot = queue_slot[lvl][p];
                r.chosen_level = lvl[1:0];
                r.chosen_position = p[5:0];
                r.found = 1'b1;
                cur_level = lvl;
                cur_pos = p + 1;
                break;
              end
              p++;
            end else begin
              lvl = (lvl + 1) % 3;
              p = 0;
            end
          end
        end
        FN_ADMIT: begin
          for (int l = 0; l < 3; l++) begin
            for (int i = 0; i < queue_len[l]; i++) begin
              if (queue_slot[l][i] == ev.slot) begin
                drop_entry(l, i);
                break;
              end
            end
          end
          wait_ticks[ev.slot] = '0;
          is_runnable[ev.slot] = 0;
          r.chosen_position = queue_len[0][5:0];
          if (!push_tail(0, ev.slot)) r.chosen_position = '0;
        end
        FN_SETRUN: is_runnable[ev.slot] = ev.runnable;
        default: begin
          lvl = 3;
          for (int l = 0; l < 3; l++) begin
            if (ev.position < queue_len[l] && queue_slot[l][ev.position] == ev.slot) begin
              lvl = l;
              break;
            end
          end
          if (lvl < 3) begin
            tgt = (lvl == 2) ? 2 : lvl + 1;
            r.chosen_level = lvl[1:0];
            r.chosen_position = ev.position;
            if (ev.duration >= quantum[lvl] && (lvl == 2 || queue_len[tgt] < SLOTS)) begin
              drop_entry(lvl, ev.position);
              void'(push_tail(tgt, ev.slot));
              r.demoted = 1'b1;
            end
            r.boosted_count = 7'(age_and_boost((lvl == 2) ? int'(ev.position) : 0,
                                                ev.duration));
          end
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("result mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  tlfq_in_if  in_bus();
  tlfq_out_if out_bus();
  tlfq_cfg_if cfg_bus();

  three_level_feedback_queue_scheduler_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  sched_scoreboard sb = new();
  bit hold_request = 0;
  bit no_gaps = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any accepted beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver with random stalls and one long hold-off on request.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 12);
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      sb.check_result({out_bus.chosen_slot, out_bus.chosen_level, out_bus.chosen_position,
                       out_bus.found, out_bus.demoted, out_bus.boosted_count});
    end
  end

  // Offer one event beat after a random gap; valid stays high across back-to-back beats.
  task automatic send_event(sched_event_t ev);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.func <= ev.func;
    in_bus.slot <= ev.slot;
    in_bus.position <= ev.position;
    in_bus.runnable <= ev.runnable;
    in_bus.duration <= ev.duration;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_request(ev);
  endtask

  task automatic send_fields(func_t f, int s, int p, bit run, int dur);
    sched_event_t ev;
    ev.func = f;
    ev.slot = s[5:0];
    ev.position = p[5:0];
    ev.runnable = run;
    ev.duration = dur[15:0];
    send_event(ev);
  endtask

  // Let every owed result arrive, then give the block time to settle.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Valid stays high so that writes can follow back to back; the caller drops it.
  task automatic write_cfg(reg_idx_t idx, int value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value[15:0];
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.write_reg(idx, value[15:0]);
  endtask

  // Random event; most reports are steered to match a queued entry.
  task automatic send_random();
    sched_event_t ev;
    int pick;
    int lvl;
    int dsel;
    ev.func = func_t'($urandom_range(0, 3));
    ev.slot = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
    ev.position = 6'($urandom);
    ev.runnable = ($urandom_range(0, 9) < 7);
    dsel = $urandom_range(0, 9);
    ev.duration = (dsel < 4) ? 16'($urandom_range(0, 10)) :
                  (dsel < 7) ? 16'($urandom_range(0, 100)) : 16'($urandom);
    pick = $urandom_range(0, 9);
    if (ev.func == FN_REPORT && pick < 8) begin
      lvl = $urandom_range(0, 2);
      for (int k = 0; k < 3 && sb.queue_len[lvl] == 0; k++) lvl = (lvl + 1) % 3;
      if (sb.queue_len[lvl] != 0) begin
        ev.position = 6'($urandom_range(0, sb.queue_len[lvl] - 1));
        ev.slot = sb.queue_slot[lvl][ev.position];
      end
    end
    send_event(ev);
  endtask

  initial begin
    int settings[4][4] = '{'{1, 1, 1, 0}, '{65535, 65535, 65535, 65535},
                           '{3, 5, 20, 200}, '{2, 4, 8, 30}};
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.func = FN_ADMIT;
    in_bus.slot = '0;
    in_bus.position = '0;
    in_bus.runnable = 1'b0;
    in_bus.duration = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_Q0;
    cfg_bus.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pick, admits, matched and unmatched reports, extremes of duration.
    send_fields(FN_PICK, 0, 0, 0, 0);
    send_fields(FN_ADMIT, 0, 0, 0, 0);
    send_fields(FN_ADMIT, 63, 0, 0, 0);
    send_fields(FN_ADMIT, 42, 63, 1, 65535);
    send_fields(FN_PICK, 63, 63, 1, 65535);
    send_fields(FN_SETRUN, 0, 0, 1, 0);
    send_fields(FN_SETRUN, 63, 63, 1, 65535);
    send_fields(FN_SETRUN, 42, 0, 1, 0);
    send_fields(FN_PICK, 0, 0, 0, 0);
    send_fields(FN_PICK, 0, 0, 0, 0);
    send_fields(FN_REPORT, 0, 0, 0, 0);
    send_fields(FN_REPORT, 63, 63, 0, 5);
    send_fields(FN_REPORT, 63, 0, 0, 65535);
    send_fields(FN_REPORT, 0, 1, 0, 2);
    send_fields(FN_REPORT, 42, 0, 0, 65535);
    send_fields(FN_SETRUN, 63, 0, 0, 0);
    send_fields(FN_PICK, 0, 0, 0, 0);
    send_fields(FN_PICK, 0, 0, 0, 0);
    send_fields(FN_REPORT, 42, 0, 0, 65535);
    send_fields(FN_REPORT, 0, 0, 0, 60);
    send_fields(FN_ADMIT, 0, 0, 0, 0);
    send_fields(FN_PICK, 0, 0, 0, 0);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_cfg(REG_Q0, settings[ph][0]);
      write_cfg(REG_Q1, settings[ph][1]);
      write_cfg(REG_Q2, settings[ph][2]);
      write_cfg(REG_BOOST, settings[ph][3]);
      cfg_bus.valid <= 1'b0;
      for (int n = 0; n < 95; n++) begin
        if (n % 25 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if (ph == 1 && n == 10) hold_request = 1;
        if (ph == 2 && n == 50) wait_drained();
        send_random();
      end
    end

    // Drain and report.
    no_gaps = 0;
    wait_drained();
    if (sb.owed.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
